// ===== rtl/ata_pkg.sv =====
// Shared constants for the accelerometer tilt angle pipeline.
package ata_pkg;

  // Axes narrower than this are scaled up to it before squaring.
  localparam int SCALED_MIN_BITS = 24;

  // Angle register: degrees with 16 fraction bits, plus sign and headroom.
  localparam int ANGLE_BITS = 26;

  // Result angle format.
  localparam int OUT_BITS      = 16;
  localparam int HALF_TURN_DEG = 180;
  localparam int ANGLE_LIMIT   = (HALF_TURN_DEG / 2) * 256;
  localparam int ROUND_HALF    = 128;
  localparam int FRAC_DROP     = 8;

  // atan(2^-i) in degrees, 16 fraction bits, rounded.
  localparam int ATAN_ENTRIES = 32;
  localparam logic [22:0] ATAN_DEG_Q16 [ATAN_ENTRIES] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
    23'd234379,  23'd117304,  23'd58666,  23'd29335,
    23'd14668,   23'd7334,    23'd3667,   23'd1833,
    23'd917,     23'd458,     23'd229,    23'd115,
    23'd57,      23'd29,      23'd14,     23'd7,
    23'd4,       23'd2,       23'd1,      23'd0,
    23'd0,       23'd0,       23'd0,      23'd0,
    23'd0,       23'd0,       23'd0,      23'd0
  };

endpackage

// ===== rtl/ata_if.sv =====
// Stream interfaces for the sample and angle channels.
interface ata_in_if #(parameter int ACCEL_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [ACCEL_BITS-1:0] accel_x;
  logic signed [ACCEL_BITS-1:0] accel_y;
  logic signed [ACCEL_BITS-1:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface ata_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_deg;
  logic signed [15:0] pitch_deg;

  modport source (output valid, output roll_deg, output pitch_deg, input ready);
  modport sink   (input valid, input roll_deg, input pitch_deg, output ready);
endinterface

// ===== rtl/accel_tilt_angles.sv =====
// Top level: roll and pitch from one accelerometer sample per word.
//
//  channel | dir | handshake              | payload
//  in_if   | in  | in_if.valid/in_if.ready   | accel_x, accel_y, accel_z
//  out_if  | out | out_if.valid/out_if.ready | roll_deg, pitch_deg
//
// One sample per clock while the output is not stalled. The pipe holds the
// front stages, the square root stages (one root bit each) over a root of
// SW = max(ACCEL_BITS, 24) bits, the CORDIC stages (one rotation each) and the output register.
// Synchronous active-low reset empties the pipe and clears the seen flag.
// The first word after reset is consumed and gives no result.
// A stalled output holds its word; each stage moves while it or a later one
// has room, so bubbles close up under backpressure.
module accel_tilt_angles #(
  parameter int ACCEL_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  ata_in_if.sink     in_if,
  ata_out_if.source  out_if
);
  localparam int SW = (ACCEL_BITS > ata_pkg::SCALED_MIN_BITS) ?
                      ACCEL_BITS : ata_pkg::SCALED_MIN_BITS;
  localparam int AW = ata_pkg::ANGLE_BITS;
  localparam int OW = ata_pkg::OUT_BITS;
  localparam logic signed [AW-1:0] LIM_HI = AW'(ata_pkg::ANGLE_LIMIT);
  localparam logic signed [AW-1:0] LIM_LO = -AW'(ata_pkg::ANGLE_LIMIT);

  logic                 fr_valid, fr_ready;
  logic [2*SW-1:0]      fr_sum_roll, fr_sum_pitch;
  logic signed [SW-1:0] fr_num_roll, fr_num_pitch;
  logic                 sq_valid, sq_ready;
  logic [SW-1:0]        sq_den_roll, sq_den_pitch;
  logic signed [SW-1:0] sq_num_roll, sq_num_pitch;
  logic                 co_valid, co_ready;
  logic signed [AW-1:0] co_ang_roll, co_ang_pitch;
  logic                 co_zero_roll, co_zero_pitch;
  logic signed [AW-1:0] rnd_roll, rnd_pitch;
  logic signed [OW-1:0] roll_nxt, pitch_nxt;
  logic signed [OW-1:0] roll_r, pitch_r;
  logic                 ov_r;

  ata_front #(.ACCEL_BITS(ACCEL_BITS), .SW(SW)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_if.valid),
    .in_ready      (in_if.ready),
    .in_x          (in_if.accel_x),
    .in_y          (in_if.accel_y),
    .in_z          (in_if.accel_z),
    .out_valid     (fr_valid),
    .out_ready     (fr_ready),
    .out_sum_roll  (fr_sum_roll),
    .out_sum_pitch (fr_sum_pitch),
    .out_num_roll  (fr_num_roll),
    .out_num_pitch (fr_num_pitch)
  );

  ata_sqrt #(.SW(SW)) u_sqrt (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (fr_valid),
    .in_ready      (fr_ready),
    .in_sum_roll   (fr_sum_roll),
    .in_sum_pitch  (fr_sum_pitch),
    .in_num_roll   (fr_num_roll),
    .in_num_pitch  (fr_num_pitch),
    .out_valid     (sq_valid),
    .out_ready     (sq_ready),
    .out_den_roll  (sq_den_roll),
    .out_den_pitch (sq_den_pitch),
    .out_num_roll  (sq_num_roll),
    .out_num_pitch (sq_num_pitch)
  );

  ata_cordic #(.SW(SW), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (sq_valid),
    .in_ready       (sq_ready),
    .in_den_roll    (sq_den_roll),
    .in_den_pitch   (sq_den_pitch),
    .in_num_roll    (sq_num_roll),
    .in_num_pitch   (sq_num_pitch),
    .out_valid      (co_valid),
    .out_ready      (co_ready),
    .out_ang_roll   (co_ang_roll),
    .out_ang_pitch  (co_ang_pitch),
    .out_zero_roll  (co_zero_roll),
    .out_zero_pitch (co_zero_pitch)
  );

  // round to 8 fraction bits, clamp to +/-90 degrees, zero pair gives 0
  assign rnd_roll  = (co_ang_roll + AW'(ata_pkg::ROUND_HALF)) >>> ata_pkg::FRAC_DROP;
  assign rnd_pitch = (co_ang_pitch + AW'(ata_pkg::ROUND_HALF)) >>> ata_pkg::FRAC_DROP;

  always_comb begin
    if (co_zero_roll)          roll_nxt = '0;
    else if (rnd_roll > LIM_HI) roll_nxt = OW'(LIM_HI);
    else if (rnd_roll < LIM_LO) roll_nxt = OW'(LIM_LO);
    else                       roll_nxt = OW'(rnd_roll);
    if (co_zero_pitch)          pitch_nxt = '0;
    else if (rnd_pitch > LIM_HI) pitch_nxt = OW'(LIM_HI);
    else if (rnd_pitch < LIM_LO) pitch_nxt = OW'(LIM_LO);
    else                        pitch_nxt = OW'(rnd_pitch);
  end

  // output register
  assign co_ready = !ov_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (co_ready) begin
      ov_r <= co_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (co_ready) begin
      roll_r  <= roll_nxt;
      pitch_r <= pitch_nxt;
    end
  end

  assign out_if.valid     = ov_r;
  assign out_if.roll_deg  = roll_r;
  assign out_if.pitch_deg = pitch_r;

  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (roll_r <= OW'(LIM_HI)) && (roll_r >= OW'(LIM_LO)))
    else $error("roll outside +/-90 degrees");
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (pitch_r <= OW'(LIM_HI)) && (pitch_r >= OW'(LIM_LO)))
    else $error("pitch outside +/-90 degrees");
endmodule

// ===== rtl/ata_front.sv =====
// Front end: first-sample drop, axis scaling, squaring and sums of squares.
module ata_front #(
  parameter int ACCEL_BITS = 16,
  parameter int SW         = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [ACCEL_BITS-1:0] in_x,
  input  logic signed [ACCEL_BITS-1:0] in_y,
  input  logic signed [ACCEL_BITS-1:0] in_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2*SW-1:0]         out_sum_roll,
  output logic [2*SW-1:0]         out_sum_pitch,
  output logic signed [SW-1:0]    out_num_roll,
  output logic signed [SW-1:0]    out_num_pitch
);
  localparam int SH = (ACCEL_BITS < ata_pkg::SCALED_MIN_BITS) ?
                      (ata_pkg::SCALED_MIN_BITS - ACCEL_BITS) : 0;

  logic first_seen_r, first_seen_nxt;
  logic v0_r, v1_r, v2_r;
  logic rdy0, rdy1, rdy2;
  logic accept;
  logic signed [SW-1:0] ex, ey, ez;
  logic signed [SW-1:0] ax_r, ay_r, az_r;
  logic signed [2*SW-1:0] sq_x, sq_y, sq_z;
  logic [2*SW-1:0] sqx_r, sqy_r, sqz_r;
  logic signed [SW-1:0] nx1_r, ny1_r;
  logic [2*SW-1:0] sum_roll_r, sum_pitch_r;
  logic signed [SW-1:0] nx2_r, ny2_r;

  // stall chain: a stage moves when empty or when the next one moves
  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign rdy0     = !v0_r || rdy1;
  assign in_ready = rdy0;
  assign accept   = in_valid && rdy0;

  // the first sample after reset only marks the flag
  assign first_seen_nxt = first_seen_r || accept;

  // sign extend, then scale up to the working width
  assign ex = SW'(in_x) <<< SH;
  assign ey = SW'(in_y) <<< SH;
  assign ez = SW'(in_z) <<< SH;

  assign sq_x = ax_r * ax_r;
  assign sq_y = ay_r * ay_r;
  assign sq_z = az_r * az_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_seen_r <= 1'b0;
      v0_r         <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
    end else begin
      first_seen_r <= first_seen_nxt;
      if (rdy0) v0_r <= accept && first_seen_r;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (rdy0) begin
      ax_r <= ex;
      ay_r <= ey;
      az_r <= ez;
    end
    if (rdy1) begin
      sqx_r <= unsigned'(sq_x);
      sqy_r <= unsigned'(sq_y);
      sqz_r <= unsigned'(sq_z);
      nx1_r <= ax_r;
      ny1_r <= ay_r;
    end
    if (rdy2) begin
      sum_roll_r  <= sqx_r + sqz_r;
      sum_pitch_r <= sqy_r + sqz_r;
      nx2_r       <= nx1_r;
      ny2_r       <= ny1_r;
    end
  end

  assign out_valid     = v2_r;
  assign out_sum_roll  = sum_roll_r;
  assign out_sum_pitch = sum_pitch_r;
  assign out_num_roll  = ny2_r;
  assign out_num_pitch = nx2_r;

  a_first_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !first_seen_r) |=> !v0_r)
    else $error("first sample was not dropped");
  a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    first_seen_r |=> first_seen_r)
    else $error("seen flag cleared without reset");
endmodule

// ===== rtl/ata_sqrt.sv =====
// Pipelined floor square root, one root bit per stage, two lanes.
module ata_sqrt #(
  parameter int SW = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2*SW-1:0]      in_sum_roll,
  input  logic [2*SW-1:0]      in_sum_pitch,
  input  logic signed [SW-1:0] in_num_roll,
  input  logic signed [SW-1:0] in_num_pitch,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SW-1:0]        out_den_roll,
  output logic [SW-1:0]        out_den_pitch,
  output logic signed [SW-1:0] out_num_roll,
  output logic signed [SW-1:0] out_num_pitch
);
  localparam int W2 = 2 * SW;

  logic                 v_r    [SW];
  logic [W2-1:0]        rem_r  [2][SW];
  logic [W2-1:0]        root_r [2][SW];
  logic signed [SW-1:0] num_r  [2][SW];
  logic                 rdy    [SW+1];

  assign rdy[SW] = out_ready;

  for (genvar k = 0; k < SW; k++) begin : g_stage
    localparam logic [W2-1:0] BIT = W2'(1) << (2 * (SW - 1 - k));
    logic                 v_src;
    logic [W2-1:0]        rem_src  [2];
    logic [W2-1:0]        root_src [2];
    logic signed [SW-1:0] num_src  [2];
    logic [W2-1:0]        trial    [2];
    logic [W2-1:0]        rem_nxt  [2];
    logic [W2-1:0]        root_nxt [2];

    if (k == 0) begin : g_head
      assign v_src       = in_valid;
      assign rem_src[0]  = in_sum_roll;
      assign rem_src[1]  = in_sum_pitch;
      assign root_src[0] = '0;
      assign root_src[1] = '0;
      assign num_src[0]  = in_num_roll;
      assign num_src[1]  = in_num_pitch;
    end else begin : g_body
      assign v_src = v_r[k-1];
      for (genvar l = 0; l < 2; l++) begin : g_lane
        assign rem_src[l]  = rem_r[l][k-1];
        assign root_src[l] = root_r[l][k-1];
        assign num_src[l]  = num_r[l][k-1];
      end
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];

    // one restoring step per lane
    always_comb begin
      for (int l = 0; l < 2; l++) begin
        trial[l] = root_src[l] + BIT;
        if (rem_src[l] >= trial[l]) begin
          rem_nxt[l]  = rem_src[l] - trial[l];
          root_nxt[l] = (root_src[l] >> 1) + BIT;
        end else begin
          rem_nxt[l]  = rem_src[l];
          root_nxt[l] = root_src[l] >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        rem_r[0][k]  <= rem_nxt[0];
        root_r[0][k] <= root_nxt[0];
        num_r[0][k]  <= num_src[0];
        rem_r[1][k]  <= rem_nxt[1];
        root_r[1][k] <= root_nxt[1];
        num_r[1][k]  <= num_src[1];
      end
    end
  end

  assign in_ready      = rdy[0];
  assign out_valid     = v_r[SW-1];
  assign out_den_roll  = root_r[0][SW-1][SW-1:0];
  assign out_den_pitch = root_r[1][SW-1][SW-1:0];
  assign out_num_roll  = num_r[0][SW-1];
  assign out_num_pitch = num_r[1][SW-1];
endmodule

// ===== rtl/ata_cordic.sv =====
// Pipelined vectoring CORDIC, one micro-rotation per stage, two lanes.
module ata_cordic #(
  parameter int SW            = 24,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [SW-1:0]                       in_den_roll,
  input  logic [SW-1:0]                       in_den_pitch,
  input  logic signed [SW-1:0]                in_num_roll,
  input  logic signed [SW-1:0]                in_num_pitch,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ata_pkg::ANGLE_BITS-1:0] out_ang_roll,
  output logic signed [ata_pkg::ANGLE_BITS-1:0] out_ang_pitch,
  output logic                                out_zero_roll,
  output logic                                out_zero_pitch
);
  localparam int XW = SW + 3;
  localparam int AW = ata_pkg::ANGLE_BITS;
  localparam int ST = CORDIC_STAGES;

  logic                 v_r   [ST];
  logic signed [XW-1:0] x_r   [2][ST];
  logic signed [XW-1:0] y_r   [2][ST];
  logic signed [AW-1:0] ang_r [2][ST];
  logic                 z_r   [2][ST];
  logic                 rdy   [ST+1];

  assign rdy[ST] = out_ready;

  for (genvar k = 0; k < ST; k++) begin : g_stage
    localparam logic signed [AW-1:0] STEP = AW'(ata_pkg::ATAN_DEG_Q16[k]);
    logic                 v_src;
    logic signed [XW-1:0] x_src   [2];
    logic signed [XW-1:0] y_src   [2];
    logic signed [AW-1:0] ang_src [2];
    logic                 z_src   [2];
    logic signed [XW-1:0] x_nxt   [2];
    logic signed [XW-1:0] y_nxt   [2];
    logic signed [AW-1:0] ang_nxt [2];

    if (k == 0) begin : g_head
      // start from (sqrt, numerator); a zero pair is flagged
      assign v_src      = in_valid;
      assign x_src[0]   = signed'(XW'(in_den_roll));
      assign x_src[1]   = signed'(XW'(in_den_pitch));
      assign y_src[0]   = XW'(in_num_roll);
      assign y_src[1]   = XW'(in_num_pitch);
      assign ang_src[0] = '0;
      assign ang_src[1] = '0;
      assign z_src[0]   = (in_den_roll == '0) && (in_num_roll == '0);
      assign z_src[1]   = (in_den_pitch == '0) && (in_num_pitch == '0);
    end else begin : g_body
      assign v_src = v_r[k-1];
      for (genvar l = 0; l < 2; l++) begin : g_lane
        assign x_src[l]   = x_r[l][k-1];
        assign y_src[l]   = y_r[l][k-1];
        assign ang_src[l] = ang_r[l][k-1];
        assign z_src[l]   = z_r[l][k-1];
      end
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];

    // rotate toward the x axis
    always_comb begin
      for (int l = 0; l < 2; l++) begin
        if (y_src[l] < 0) begin
          x_nxt[l]   = x_src[l] - (y_src[l] >>> k);
          y_nxt[l]   = y_src[l] + (x_src[l] >>> k);
          ang_nxt[l] = ang_src[l] - STEP;
        end else begin
          x_nxt[l]   = x_src[l] + (y_src[l] >>> k);
          y_nxt[l]   = y_src[l] - (x_src[l] >>> k);
          ang_nxt[l] = ang_src[l] + STEP;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        x_r[0][k]   <= x_nxt[0];
        y_r[0][k]   <= y_nxt[0];
        ang_r[0][k] <= ang_nxt[0];
        z_r[0][k]   <= z_src[0];
        x_r[1][k]   <= x_nxt[1];
        y_r[1][k]   <= y_nxt[1];
        ang_r[1][k] <= ang_nxt[1];
        z_r[1][k]   <= z_src[1];
      end
    end
  end

  assign in_ready       = rdy[0];
  assign out_valid      = v_r[ST-1];
  assign out_ang_roll   = ang_r[0][ST-1];
  assign out_ang_pitch  = ang_r[1][ST-1];
  assign out_zero_roll  = z_r[0][ST-1];
  assign out_zero_pitch = z_r[1][ST-1];
endmodule
